// ===== rtl/core/nstl_pkg.sv =====
`timescale 1ns / 1ps

package nstl_pkg;

	localparam int SITES = 1024;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W = $clog2(SITES);
	localparam int CNT_W = $clog2(SITES + 1);

	// Opcodes carried by an input item.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_VOXEL    = 3'd3;
	localparam logic [2:0] REG_OFFSET   = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_wr;     // write a site at the current count
		logic clear;       // empty the table
		logic capture;     // latch query operands
		logic scan_rd;     // read entry at scan index
		logic scan_cmp;    // compare the entry read last cycle
		logic scan_first;  // that entry is the first one
		logic fetch;       // read best entry traction
		logic mul_start;   // begin force computation
		logic [2:0] axis;  // axis being scaled
		logic mul_take;    // store the scaled force of that axis
		logic sq_start;    // begin magnitude
		logic sq_step;     // one root step
		logic out_load;    // latch result
		logic empty_res;   // result is the empty-table answer
	} cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic empty;
		logic full;
		logic scan_last;
		logic sq_done;
	} stat_t;

	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'h7fffffff;
		if (v < -34'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

endpackage

// ===== rtl/core/nstl_ctrl.sv =====
`timescale 1ns / 1ps

module nstl_ctrl import nstl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  stat_t      st,
	output cmd_t       cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_LAST  = 4'd2;
	localparam logic [3:0] S_FETCH = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_TAKE  = 4'd5;
	localparam logic [3:0] S_SQ    = 4'd6;
	localparam logic [3:0] S_DONE  = 4'd7;

	logic [3:0] state_q;
	logic [1:0] axis_q;
	logic       cap_q;
	logic       first_q;
	logic       cmp_q;
	logic       ovalid_q;

	assign out_valid = ovalid_q;
	assign in_ready = (state_q == S_IDLE) && !ovalid_q;

	// Command decode.
	always_comb begin
		cmd = '0;
		cmd.scan_cmp = cmp_q;
		cmd.scan_first = first_q;
		cmd.axis = 3'b001 << axis_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load_wr = (in_op == OP_LOAD) && !st.full;
					cmd.clear = (in_op == OP_CLEAR);
					if (in_op == OP_QUERY) begin
						cmd.capture = 1'b1;
						cmd.empty_res = st.empty;
						cmd.out_load = st.empty;
					end
				end
			end
			S_SCAN: cmd.scan_rd = 1'b1;
			S_FETCH: cmd.fetch = 1'b1;
			S_MUL: cmd.mul_start = 1'b1;
			S_TAKE: begin
				cmd.mul_take = 1'b1;
				cmd.sq_start = (axis_q == 2'd2);
			end
			S_SQ: begin
				cmd.sq_step = 1'b1;
				cmd.out_load = st.sq_done;
			end
			default: ;
		endcase
	end

	// Sequencing. The capture strobe is delayed through cap_q and first_q to mark the first entry's compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= 2'd0;
			cap_q <= 1'b0;
			first_q <= 1'b0;
			cmp_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			cmp_q <= cmd.scan_rd;
			cap_q <= cmd.capture;
			first_q <= cap_q;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready && in_op == OP_QUERY) begin
						if (st.empty) ovalid_q <= 1'b1;
						else state_q <= S_SCAN;
					end
				end
				S_SCAN: if (st.scan_last) state_q <= S_LAST;
				S_LAST: state_q <= S_FETCH;
				S_FETCH: begin
					axis_q <= 2'd0;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_TAKE;
				S_TAKE: begin
					if (axis_q == 2'd2) state_q <= S_SQ;
					else begin
						axis_q <= axis_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_SQ: begin
					if (st.sq_done) begin
						ovalid_q <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: if (!ovalid_q) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/nstl_dp.sv =====
`timescale 1ns / 1ps

module nstl_dp import nstl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_val,
	input  logic [15:0] grid_x,
	input  logic [15:0] grid_y,
	input  logic [15:0] grid_z,
	input  logic [31:0] raw_traction_x,
	input  logic [31:0] raw_traction_y,
	input  logic [31:0] raw_traction_z,
	input  logic [31:0] where_x,
	input  logic [31:0] where_y,
	input  logic [31:0] where_z,
	input  logic [31:0] cell_area,
	input  cmd_t        cmd,
	output stat_t       st,
	output logic [IDX_W-1:0] site_index,
	output logic [31:0] force_x,
	output logic [31:0] force_y,
	output logic [31:0] force_z,
	output logic [31:0] force_magnitude,
	output logic        no_site
);

	logic [31:0] org_x_q, org_y_q, org_z_q, voxel_q, offset_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] scan_q, cmp_idx_q, best_q;
	logic [31:0] px_mem [SITES];
	logic [31:0] py_mem [SITES];
	logic [31:0] pz_mem [SITES];
	logic [31:0] tx_mem [SITES];
	logic [31:0] ty_mem [SITES];
	logic [31:0] tz_mem [SITES];
	logic [31:0] rpx_q, rpy_q, rpz_q;
	logic [31:0] rtx_q, rty_q, rtz_q;
	logic [31:0] wx_q, wy_q, wz_q, area_q;
	logic [65:0] best_d_q;
	logic [31:0] t_sel;
	logic [63:0] prod_q;
	logic        neg_q;
	logic [31:0] fx_q, fy_q, fz_q;
	logic [63:0] sqv_q, sqres_q, sqbit_q;
	logic [5:0]  sqn_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			voxel_q <= 32'd65536;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ORIGIN_X: org_x_q <= cfg_val;
				REG_ORIGIN_Y: org_y_q <= cfg_val;
				REG_ORIGIN_Z: org_z_q <= cfg_val;
				REG_VOXEL: voxel_q <= cfg_val;
				REG_OFFSET: offset_q <= cfg_val;
				default: ;
			endcase
		end
	end

	// Site position from grid coordinate, saturated.
	function automatic logic [31:0] grid_pos(input logic [31:0] org, input logic [31:0] vox,
			input logic [15:0] g);
		logic signed [49:0] s;
		s = $signed({{18{org[31]}}, org}) + $signed({2'b00, vox * {32'd0, g}});
		if (s > 50'sd2147483647) return 32'h7fffffff;
		if (s < -50'sd2147483648) return 32'h80000000;
		return s[31:0];
	endfunction

	function automatic logic [31:0] add_off(input logic [31:0] a, input logic [31:0] b);
		return sat32($signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b}));
	endfunction

	assign st.empty = (count_q == '0);
	assign st.full = (count_q == CNT_W'(SITES));
	assign st.scan_last = (CNT_W'(scan_q) + 1'b1 == count_q);

	// Table count and scan index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q <= '0;
		end else begin
			if (cmd.clear) count_q <= '0;
			else if (cmd.load_wr) count_q <= count_q + 1'b1;
			if (cmd.capture) scan_q <= '0;
			else if (cmd.scan_rd) scan_q <= scan_q + 1'b1;
		end
	end

	// Site memories: one write port, one read port.
	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			px_mem[count_q[IDX_W-1:0]] <= grid_pos(org_x_q, voxel_q, grid_x);
			py_mem[count_q[IDX_W-1:0]] <= grid_pos(org_y_q, voxel_q, grid_y);
			pz_mem[count_q[IDX_W-1:0]] <= grid_pos(org_z_q, voxel_q, grid_z);
			tx_mem[count_q[IDX_W-1:0]] <= add_off(raw_traction_x, offset_q);
			ty_mem[count_q[IDX_W-1:0]] <= add_off(raw_traction_y, offset_q);
			tz_mem[count_q[IDX_W-1:0]] <= add_off(raw_traction_z, offset_q);
		end
		rpx_q <= px_mem[scan_q];
		rpy_q <= py_mem[scan_q];
		rpz_q <= pz_mem[scan_q];
		if (cmd.fetch) begin
			rtx_q <= tx_mem[best_q];
			rty_q <= ty_mem[best_q];
			rtz_q <= tz_mem[best_q];
		end
		cmp_idx_q <= scan_q;
	end

	function automatic logic [63:0] sq_diff(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		logic [31:0] m;
		d = $signed({a[31], a}) - $signed({b[31], b});
		m = d[32] ? 32'(-d) : d[31:0];
		return m * m;
	endfunction

	// Distance compare, first minimum wins.
	logic [65:0] sq_dist;
	assign sq_dist = {2'b00, sq_diff(wx_q, rpx_q)} + {2'b00, sq_diff(wy_q, rpy_q)}
		+ {2'b00, sq_diff(wz_q, rpz_q)};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			wx_q <= where_x;
			wy_q <= where_y;
			wz_q <= where_z;
			area_q <= cell_area;
			best_q <= '0;
		end else if (cmd.scan_cmp && (cmd.scan_first || sq_dist < best_d_q)) begin
			best_d_q <= sq_dist;
			best_q <= cmp_idx_q;
		end
	end

	// Force scaling, one axis at a time.
	always_comb begin
		case (cmd.axis)
			3'b010: t_sel = rty_q;
			3'b100: t_sel = rtz_q;
			default: t_sel = rtx_q;
		endcase
	end

	logic [31:0] t_mag;
	assign t_mag = t_sel[31] ? 32'(-t_sel) : t_sel;

	logic [47:0] q_mag;
	logic signed [49:0] q_s;
	logic [31:0] f_sat;
	assign q_mag = neg_q ? 48'((prod_q + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS)
		: 48'(prod_q >> FRAC_BITS);
	assign q_s = neg_q ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
	assign f_sat = (q_s > 50'sd2147483647) ? 32'h7fffffff :
		(q_s < -50'sd2147483648) ? 32'h80000000 : q_s[31:0];

	function automatic logic [63:0] fsq(input logic [31:0] f);
		logic [31:0] m;
		m = f[31] ? 32'(-f) : f;
		return m * m;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			prod_q <= {32'd0, t_mag} * {32'd0, area_q};
			neg_q <= t_sel[31];
		end
		if (cmd.mul_take) begin
			if (cmd.axis[0]) fx_q <= f_sat;
			if (cmd.axis[1]) fy_q <= f_sat;
			if (cmd.axis[2]) fz_q <= f_sat;
		end
	end

	// Square root, one result bit per step over 32 steps.
	logic [63:0] sq_sum;
	assign sq_sum = fsq(fx_q) + fsq(fy_q) + fsq(f_sat);
	logic [63:0] trial;
	assign trial = sqres_q + sqbit_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_start) begin
			sqv_q <= sq_sum;
			sqres_q <= '0;
			sqbit_q <= 64'd1 << 62;
			sqn_q <= '0;
		end else if (cmd.sq_step && !st.sq_done) begin
			if (sqv_q >= trial) begin
				sqv_q <= sqv_q - trial;
				sqres_q <= (sqres_q >> 1) + sqbit_q;
			end else begin
				sqres_q <= sqres_q >> 1;
			end
			sqbit_q <= sqbit_q >> 2;
			sqn_q <= sqn_q + 6'd1;
		end
	end
	assign st.sq_done = (sqn_q == 6'd32);

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			no_site <= cmd.empty_res;
			site_index <= cmd.empty_res ? '0 : best_q;
			force_x <= cmd.empty_res ? '0 : fx_q;
			force_y <= cmd.empty_res ? '0 : fy_q;
			force_z <= cmd.empty_res ? '0 : fz_q;
			force_magnitude <= cmd.empty_res ? '0 : sqres_q[31:0];
		end
	end

endmodule

// ===== rtl/core/nearest_site_traction_lookup_core.sv =====
`timescale 1ns / 1ps
// Clear and load items are done in the idle state without leaving it; a query on an empty table answers next cycle.
// A query on a non-empty table with N stored sites scans them one site per cycle through the position
// memory read port, then does three force multiplies, one axis at a time, then a 32-step square root
// before it raises m_tvalid.
// One item is in work at a time; the next is accepted only after the result is taken and the control is back in idle.
// arst_n clears the site count, control state and configuration to their reset values.

module nearest_site_traction_lookup_core import nstl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode, grid_x, grid_y, grid_z, raw_traction_x/y/z, where_x/y/z, cell_area, pad
	input  logic [311:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// site_index, force_x, force_y, force_z, force_magnitude, pad
	output logic [143:0] m_tdata,
	// no_site
	output logic         m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cmd_t cmd;
	stat_t st;
	logic [IDX_W-1:0] site_index;
	logic [31:0] fx, fy, fz, fm;

	assign cfg_ready = 1'b1;
	assign m_tdata = {6'd0, fm, fz, fy, fx, site_index};

	nstl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_op(s_tdata[1:0]), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.st(st), .cmd(cmd)
	);

	nstl_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
		.grid_x(s_tdata[17:2]), .grid_y(s_tdata[33:18]), .grid_z(s_tdata[49:34]),
		.raw_traction_x(s_tdata[81:50]), .raw_traction_y(s_tdata[113:82]),
		.raw_traction_z(s_tdata[145:114]),
		.where_x(s_tdata[177:146]), .where_y(s_tdata[209:178]),
		.where_z(s_tdata[241:210]), .cell_area(s_tdata[273:242]),
		.cmd(cmd), .st(st),
		.site_index(site_index), .force_x(fx), .force_y(fy), .force_z(fz),
		.force_magnitude(fm), .no_site(m_tuser)
	);

endmodule
